// File: hdl/tcw_pkg.sv
// Package for the text console writer: geometry, codes, channel payload types, datapath command and status types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;
    localparam int ScreenCols = 80;
    localparam int ScreenRows = 25;
    localparam int MaxDigits  = 20;
    localparam int CellCount  = ScreenCols * ScreenRows;
    localparam int AddrW      = $clog2(CellCount);
    localparam int ColW       = $clog2(ScreenCols);
    localparam int RowW       = $clog2(ScreenRows + 1);
    localparam int DigW       = $clog2(MaxDigits + 1);

    localparam logic [7:0] BlankChar   = 8'd32;
    localparam logic [7:0] NewlineChar = 8'd10;
    localparam logic [7:0] DigitBase   = 8'd48;
    localparam logic [7:0] ResetAttr   = 8'd15;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_NUM   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    localparam logic REG_ATTR   = 1'b0;
    localparam logic REG_CURSOR = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [63:0] number_value;
        logic [10:0] cell_address;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic        cursor_shown;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_out_item;

    // datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,       // latch input item
        CMD_FILL,       // write blank at sweep address, step sweep
        CMD_FILL_START, // sweep, cursor, column and row to 0
        CMD_WRITE_CH,   // write current char at cursor, advance
        CMD_NEWLINE,    // cursor to next row start
        CMD_SCR_RD,     // read cell at sweep + cols
        CMD_SCR_WR,     // write read cell to sweep, step
        CMD_SCR_LAST,   // zero char of last row cell, step
        CMD_SCR_END,    // cursor back one row
        CMD_DIV,        // one divide-by-ten step on a 16-bit chunk
        CMD_DIV_DONE,   // push digit, next number
        CMD_POP,        // pop digit into current char
        CMD_READ,       // read cell at address
        CMD_RESULT      // register result
    } t_cmd;

    typedef struct packed {
        logic cursor_end;   // cursor at or beyond end of screen
        logic sweep_done;   // sweep at last cell of its range
        logic div_done;     // current division step is the last
        logic num_zero;     // quotient zero or digit limit
        logic digits_empty;
        logic is_newline;
        logic [1:0] op;
    } t_status;
endpackage
`default_nettype wire

// File: hdl/tcw_datapath.sv
// Datapath: screen store, cursor, sweep counter, divide-by-ten unit, digit stack.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_datapath (
    input  wire logic              i_clk,
    input  wire tcw_pkg::t_cmd     i_cmd,
    input  wire tcw_pkg::t_in_item i_item,
    input  wire logic [7:0]        i_attr,
    input  wire logic              i_cursor_en,
    output tcw_pkg::t_status       o_status,
    output tcw_pkg::t_out_item     o_result
);
    import tcw_pkg::*;

    localparam int SweepW = AddrW + 1;
    // ceil(2^23 / 10): exact quotient for any 20-bit chunk below 10 * 2^16
    localparam logic [19:0] RecipTen = 20'd838861;

    logic [15:0] r_mem [CellCount];
    logic [15:0] r_rd;
    t_in_item    r_item;
    logic [SweepW-1:0] r_cursor;
    logic [SweepW-1:0] r_sweep;
    logic [7:0]  r_ch;
    logic [63:0] r_quo;
    logic [3:0]  r_rem;
    logic [6:0]  r_bit;
    logic [3:0]  r_dig [MaxDigits];
    logic [DigW-1:0] r_cnt;
    t_out_item   r_res;
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;

    logic [19:0] w_chunk;
    logic [39:0] w_prod;
    logic [15:0] w_qd;
    logic [19:0] w_rem;
    logic [SweepW-1:0] w_src;
    logic [SweepW-1:0] w_src1;
    logic [SweepW-1:0] w_nxt;
    logic        w_scr_last;

    // divide by ten, 16 bits per step, remainder carried into the next chunk
    assign w_chunk = {r_rem, r_quo[63:48]};
    assign w_prod  = 40'(w_chunk) * 40'(RecipTen);
    assign w_qd    = w_prod[38:23];
    assign w_rem   = w_chunk - {1'b0, w_qd, 3'b000} - {3'b000, w_qd, 1'b0};

    assign w_src      = r_sweep + SweepW'(ScreenCols);
    assign w_src1     = r_sweep + SweepW'(ScreenCols + 1);
    assign w_nxt      = r_sweep + 1'b1;
    assign w_scr_last = r_sweep == SweepW'(CellCount - ScreenCols - 1);

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_FILL:     r_mem[r_sweep[AddrW-1:0]] <= {i_attr, BlankChar};
            CMD_WRITE_CH: r_mem[r_cursor[AddrW-1:0]] <= {i_attr, r_ch};
            CMD_SCR_WR:   r_mem[r_sweep[AddrW-1:0]] <= r_rd;
            CMD_SCR_LAST: r_mem[r_sweep[AddrW-1:0]] <= {r_rd[15:8], 8'd0};
            default: ;
        endcase
        // scroll reads run one cell ahead of the write
        unique case (i_cmd)
            CMD_SCR_RD:   r_rd <= r_mem[w_src[AddrW-1:0]];
            CMD_SCR_WR:   r_rd <= r_mem[w_scr_last ? w_nxt[AddrW-1:0] : w_src1[AddrW-1:0]];
            CMD_SCR_LAST: r_rd <= r_mem[w_nxt[AddrW-1:0]];
            CMD_SCR_END:  r_rd <= r_mem[r_sweep[AddrW-1:0]];
            CMD_READ:     r_rd <= r_mem[r_item.cell_address];
            default:      r_rd <= r_mem[r_sweep[AddrW-1:0]];
        endcase
    end

    // cursor, sweep, divider, digit stack and result register
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_item <= i_item;
                r_ch   <= i_item.char_code;
                r_quo  <= i_item.number_value;
                r_rem  <= '0;
                r_bit  <= '0;
                r_cnt  <= '0;
            end
            CMD_FILL_START: begin
                r_sweep <= '0;
                r_cursor <= '0;
                r_col <= '0;
                r_row <= '0;
            end
            CMD_FILL, CMD_SCR_WR, CMD_SCR_LAST: r_sweep <= r_sweep + 1'b1;
            CMD_WRITE_CH: begin
                r_cursor <= r_cursor + 1'b1;
                if (r_col == ColW'(ScreenCols - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                r_sweep <= '0;
            end
            CMD_NEWLINE: begin
                r_cursor <= SweepW'((32'(r_row) + 32'd1) * ScreenCols);
                r_col <= '0;
                r_row <= r_row + 1'b1;
                r_sweep <= '0;
            end
            CMD_SCR_RD: ;
            CMD_SCR_END: begin
                r_cursor <= r_cursor - SweepW'(ScreenCols);
                r_row <= r_row - 1'b1;
                r_sweep <= '0;
            end
            CMD_DIV: begin
                r_rem <= w_rem[3:0];
                r_quo <= {r_quo[47:0], w_qd};
                r_bit <= r_bit + 1'b1;
            end
            CMD_DIV_DONE: begin
                r_dig[r_cnt[DigW-1:0] < DigW'(MaxDigits) ? r_cnt : '0] <= r_rem;
                r_cnt <= r_cnt + 1'b1;
                r_rem <= '0;
                r_bit <= '0;
            end
            CMD_POP: begin
                r_ch  <= DigitBase + {4'd0, r_dig[r_cnt - 1'b1]};
                r_cnt <= r_cnt - 1'b1;
            end
            CMD_RESULT: begin
                r_res.cursor_pos   <= 11'(r_cursor);
                r_res.cursor_shown <= i_cursor_en;
                if (r_item.op == OP_READ && r_item.cell_address < AddrW'(CellCount)) begin
                    r_res.cell_char <= r_rd[7:0];
                    r_res.cell_attr <= r_rd[15:8];
                end else begin
                    r_res.cell_char <= '0;
                    r_res.cell_attr <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.cursor_end   = r_cursor >= SweepW'(CellCount);
        o_status.sweep_done   = (i_cmd == CMD_SCR_WR || i_cmd == CMD_SCR_RD)
                              ? w_scr_last
                              : (r_sweep == SweepW'(CellCount - 1));
        o_status.div_done     = r_bit == 7'd3;
        o_status.num_zero     = (r_quo == 64'd0) || (r_cnt == DigW'(MaxDigits));
        o_status.digits_empty = r_cnt == '0;
        o_status.is_newline   = r_ch == NewlineChar;
        o_status.op           = r_item.op;
    end

    assign o_result = r_res;
endmodule
`default_nettype wire

// File: hdl/tcw_control.sv
// Controller FSM: sequences the datapath for each op and runs the handshakes.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tcw_control (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire tcw_pkg::t_status i_status,
    output tcw_pkg::t_cmd         o_cmd,
    output logic                  o_reset_fill
);
    import tcw_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_INIT_FILL, S_IDLE, S_DISPATCH, S_CLR, S_PUT, S_CHECK,
        S_SCR_RD, S_SCR_WR, S_SCR_LAST, S_DIV, S_DIVD, S_POP, S_READ,
        S_RESULT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_num;

    assign o_in_stall   = !(r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_reset_fill = (r_state == S_INIT_FILL);

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = CMD_NONE;
        unique case (r_state)
            S_INIT: begin o_cmd = CMD_FILL_START; n_state = S_INIT_FILL; end
            S_INIT_FILL: begin
                o_cmd = CMD_FILL;
                if (i_status.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: if (i_in_valid) begin o_cmd = CMD_LOAD; n_state = S_DISPATCH; end
            S_DISPATCH: begin
                unique case (i_status.op)
                    OP_PUT:   n_state = S_PUT;
                    OP_CLEAR: begin o_cmd = CMD_FILL_START; n_state = S_CLR; end
                    OP_NUM:   n_state = S_DIV;
                    default:  n_state = S_READ;
                endcase
            end
            S_CLR: begin
                o_cmd = CMD_FILL;
                if (i_status.sweep_done) n_state = S_RESULT;
            end
            S_PUT: begin
                o_cmd = i_status.is_newline ? CMD_NEWLINE : CMD_WRITE_CH;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.cursor_end) begin
                    o_cmd = CMD_SCR_RD; n_state = S_SCR_WR;
                end else if (r_num && !i_status.digits_empty) begin
                    o_cmd = CMD_POP; n_state = S_PUT;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_SCR_RD: begin o_cmd = CMD_SCR_RD; n_state = S_SCR_WR; end
            S_SCR_WR: begin
                o_cmd = CMD_SCR_WR;
                if (i_status.sweep_done) n_state = S_SCR_LAST;
            end
            S_SCR_LAST: begin
                o_cmd = CMD_SCR_LAST;
                if (i_status.sweep_done) begin
                    o_cmd = CMD_SCR_LAST; n_state = S_POP;
                end
            end
            S_POP: begin o_cmd = CMD_SCR_END; n_state = S_CHECK; end
            S_DIV: begin
                o_cmd = CMD_DIV;
                if (i_status.div_done) n_state = S_DIVD;
            end
            S_DIVD: begin
                o_cmd = CMD_DIV_DONE;
                n_state = S_READ;
            end
            S_READ: begin
                if (r_num) begin
                    if (i_status.num_zero) begin
                        o_cmd = CMD_POP; n_state = S_PUT;
                    end else begin
                        n_state = S_DIV;
                    end
                end else begin
                    o_cmd = CMD_READ; n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                o_cmd = CMD_RESULT; n_out_valid = 1'b1; n_state = S_OUT;
            end
            S_OUT: if (!i_out_stall) begin n_out_valid = 1'b0; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    // state, result valid, number-mode flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_out_valid <= 1'b0;
            r_num <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == S_DISPATCH) r_num <= (i_status.op == OP_NUM);
        end
    end
endmodule
`default_nettype wire

// File: hdl/text_console_writer.sv
// Top level of the text console writer: config registers, controller, datapath.
// Depends on tcw_pkg, tcw_control and tcw_datapath.
//
//  channel | direction | handshake         | payload
//  in      | input     | i_in_valid/o_in_stall   | tcw_pkg::t_in_item
//  out     | output    | o_out_valid/i_out_stall | tcw_pkg::t_out_item
//  cfg     | input     | i_cfg_valid/o_cfg_ready | index, 8-bit data
//
// A character runs the dispatch, put, check and result states; a read runs
// dispatch, read and result. A scroll or clear sweeps the store cell by cell.
// A number runs, per digit, four divide steps, push, test, write and check.
// After reset a fill pass blanks the store with input stalled.
// The result is held until i_out_stall is low; the next item waits for that.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tcw_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tcw_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import tcw_pkg::*;

    logic [7:0] r_attr;
    logic       r_cursor_en;
    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_reset_fill;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ResetAttr;
            r_cursor_en <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ATTR:   r_attr <= i_cfg_data;
                REG_CURSOR: r_cursor_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tcw_control u_control (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .i_status(w_status), .o_cmd(w_cmd), .o_reset_fill(w_reset_fill)
    );

    tcw_datapath u_datapath (
        .i_clk, .i_cmd(w_cmd), .i_item(i_in_data),
        .i_attr(w_reset_fill ? ResetAttr : r_attr), .i_cursor_en(r_cursor_en),
        .o_status(w_status), .o_result(o_out_data)
    );
endmodule
`default_nettype wire
